// ===== rtl/psrl_pkg.sv =====
// Package with the shared types and codes of the per-source connection rate limiter.
`timescale 1ns / 1ps
`default_nettype none

package psrl_pkg;

   // Field widths fixed by the interface.
   localparam int ADDR_BITS     = 32;
   localparam int NOW_BITS      = 48;
   localparam int COUNT_BITS    = 8;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int PENALTY_BITS  = 16;
   localparam int WINDOW_BITS   = 16;
   localparam int LIMIT_BITS    = 8;
   localparam int DURATION_BITS = 20;

   // Register reset values.
   localparam logic [PENALTY_BITS-1:0]  PENALTY_RESET  = 16'd250;
   localparam logic [WINDOW_BITS-1:0]   WINDOW_RESET   = 16'd5000;
   localparam logic [LIMIT_BITS-1:0]    LIMIT_RESET    = 8'd5;
   localparam logic [WINDOW_BITS-1:0]   FAST_RESET     = 16'd500;
   localparam logic [DURATION_BITS-1:0] DURATION_RESET = 20'd3000;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_PENALTY  = 3'd0,
      CSR_WINDOW   = 3'd1,
      CSR_LIMIT    = 3'd2,
      CSR_FAST     = 3'd3,
      CSR_DURATION = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      VERDICT_TRACKED   = 3'd0,
      VERDICT_BLOCKED   = 3'd1,
      VERDICT_NEW_BLOCK = 3'd2,
      VERDICT_NEW_ENTRY = 3'd3,
      VERDICT_UNTRACKED = 3'd4
   } verdict_type;

   typedef enum logic {
      ALU_ADD,
      ALU_SUB
   } alu_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_CHECK,
      ST_PENALTY,
      ST_GAP,
      ST_WINDOW,
      ST_FAST,
      ST_COUNT,
      ST_BLOCK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] client_ip;
      logic [NOW_BITS-1:0]  now_ms;
   } req_type;

   typedef struct packed {
      logic        accepted;
      verdict_type verdict;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/psrl_alu.sv =====
// Shared time adder and subtractor with carry or borrow out.
`timescale 1ns / 1ps
`default_nettype none

module psrl_alu #(
   parameter int WIDTH = 48
) (
   input  wire psrl_pkg::alu_op_type op,
   input  wire logic [WIDTH-1:0]     a,
   input  wire logic [WIDTH-1:0]     b,
   output logic [WIDTH-1:0]          result,
   output logic                      carry
);
   import psrl_pkg::*;

   logic [WIDTH:0] wide;

   // On a subtract, carry is the borrow: it is set when b is greater than a.
   always_comb begin
      if (op == ALU_ADD) begin
         wide = {1'b0, a} + {1'b0, b};
      end else begin
         wide = {1'b0, a} - {1'b0, b};
      end
   end

   assign result = wide[WIDTH-1:0];
   assign carry  = wide[WIDTH];

endmodule

`default_nettype wire

// ===== rtl/per_source_connection_rate_limiter.sv =====
// Top level of the per-source connection rate limiter: sequencer, record table and registers.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Direction  Handshake                Payload
// req      in         req_valid / req_stall    client_ip, now_ms
// rsp      out        rsp_valid / rsp_stall    accepted, verdict
// csr      in         csr_valid / csr_ready    csr_index, csr_data
//
// Requests are taken only in the idle state, so the block handles one item at a time.
// The table is scanned one record per cycle through the single read port of the
// record memory; the time arithmetic then runs step by step through one shared
// adder.
// Reset is synchronous; a fill count marks the used records, so no clearing pass
// is needed and the block accepts items right after reset.
// The result sits in an output register; a stall on rsp holds it there while the
// block takes the next item, and only a finished item waiting on a full output
// register holds the sequencer.

module per_source_connection_rate_limiter #(
   parameter int TABLE_ENTRIES = 64,
   parameter int TIME_BITS     = 48
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,

   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire psrl_pkg::req_type                     req_data,

   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output psrl_pkg::rsp_type                          rsp_data,

   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [psrl_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  wire logic [psrl_pkg::CSR_DATA_BITS-1:0]    csr_data
);
   import psrl_pkg::*;

   localparam int IDX_BITS  = $clog2(TABLE_ENTRIES);
   localparam int FILL_BITS = $clog2(TABLE_ENTRIES + 1);

   // One record of the source table.
   typedef struct packed {
      logic [ADDR_BITS-1:0]  addr;
      logic [TIME_BITS-1:0]  last;
      logic [TIME_BITS-1:0]  block;
      logic [COUNT_BITS-1:0] count;
   } rec_type;

   // Configuration registers.
   logic [PENALTY_BITS-1:0]  penalty_ff;
   logic [WINDOW_BITS-1:0]   window_ff;
   logic [LIMIT_BITS-1:0]    limit_ff;
   logic [WINDOW_BITS-1:0]   fast_ff;
   logic [DURATION_BITS-1:0] duration_ff;

   // Sequencer and item state.
   state_type                state_ff;
   state_type                state_in;
   logic [ADDR_BITS-1:0]     ip_ff;
   logic [TIME_BITS-1:0]     now_ff;
   logic [FILL_BITS-1:0]     fill_ff;
   logic [FILL_BITS-1:0]     scan_cnt_ff;
   logic                     rd_pend_ff;
   logic [IDX_BITS-1:0]      rd_idx_ff;
   rec_type                  rd_rec_ff;
   rec_type                  rec_ff;
   logic [IDX_BITS-1:0]      hit_idx_ff;
   logic [TIME_BITS-1:0]     diff_ff;
   logic                     in_win_ff;
   logic                     in_fast_ff;
   verdict_type              verdict_ff;

   // Output register.
   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   // Record memory.
   rec_type                  table_mem [TABLE_ENTRIES];

   // Combinational control.
   logic                     req_take;
   logic                     rd_issue;
   logic                     scan_hit;
   logic                     scan_miss;
   logic                     table_full;
   logic                     rsp_free;
   logic                     mem_wr;
   logic [COUNT_BITS:0]      count_next;
   logic                     count_over;
   logic [TIME_BITS-1:0]     alu_sat;
   alu_op_type               alu_op;
   logic [TIME_BITS-1:0]     alu_a;
   logic [TIME_BITS-1:0]     alu_b;
   logic [TIME_BITS-1:0]     alu_result;
   logic                     alu_carry;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;
   assign table_full = (fill_ff == FILL_BITS'(TABLE_ENTRIES));

   // The scan issues one read a cycle over the filled records; the compare sees
   // the registered read data in the next cycle, so records are checked in order.
   assign rd_issue  = (state_ff == ST_SCAN) && (scan_cnt_ff != fill_ff);
   assign scan_hit  = rd_pend_ff && (rd_rec_ff.addr == ip_ff);
   assign scan_miss = !rd_pend_ff && !rd_issue;

   // Burst counting is done in one extra bit so the compare sees the carry.
   assign count_next = {1'b0, rec_ff.count} + (COUNT_BITS + 1)'(1);
   assign count_over = (count_next > {1'b0, limit_ff});

   // Any carry out of an add means the time went past the largest timestamp.
   assign alu_sat = alu_carry ? '1 : alu_result;

   psrl_alu #(
      .WIDTH (TIME_BITS)
   ) u_alu (
      .op     (alu_op),
      .a      (alu_a),
      .b      (alu_b),
      .result (alu_result),
      .carry  (alu_carry)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_hit) begin
               state_in = ST_CHECK;
            end else if (scan_miss) begin
               state_in = ST_FINISH;
            end
         end
         ST_CHECK: begin
            // A borrow from now minus block-until means the source is still blocked.
            state_in = alu_carry ? ST_PENALTY : ST_GAP;
         end
         ST_PENALTY: state_in = ST_FINISH;
         ST_GAP:     state_in = ST_WINDOW;
         ST_WINDOW:  state_in = ST_FAST;
         ST_FAST:    state_in = ST_COUNT;
         ST_COUNT: begin
            if (in_win_ff && count_over && in_fast_ff) begin
               state_in = ST_BLOCK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_BLOCK:   state_in = ST_FINISH;
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // Shared adder operands and table write strobe.
   always_comb begin
      alu_op = ALU_SUB;
      alu_a  = now_ff;
      alu_b  = rec_ff.block;
      mem_wr = 1'b0;
      unique case (state_ff)
         ST_CHECK: begin
            alu_op = ALU_SUB;
            alu_a  = now_ff;
            alu_b  = rec_ff.block;
         end
         ST_PENALTY: begin
            alu_op = ALU_ADD;
            alu_a  = rec_ff.block;
            alu_b  = TIME_BITS'(penalty_ff);
         end
         ST_GAP: begin
            alu_op = ALU_SUB;
            alu_a  = now_ff;
            alu_b  = rec_ff.last;
         end
         ST_WINDOW: begin
            alu_op = ALU_SUB;
            alu_a  = TIME_BITS'(window_ff);
            alu_b  = diff_ff;
         end
         ST_FAST: begin
            alu_op = ALU_SUB;
            alu_a  = TIME_BITS'(fast_ff);
            alu_b  = diff_ff;
         end
         ST_BLOCK: begin
            alu_op = ALU_ADD;
            alu_a  = now_ff;
            alu_b  = TIME_BITS'(duration_ff);
         end
         ST_FINISH: begin
            mem_wr = (verdict_ff != VERDICT_UNTRACKED);
         end
         default: begin
            alu_op = ALU_SUB;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         rd_pend_ff  <= 1'b0;
         penalty_ff  <= PENALTY_RESET;
         window_ff   <= WINDOW_RESET;
         limit_ff    <= LIMIT_RESET;
         fast_ff     <= FAST_RESET;
         duration_ff <= DURATION_RESET;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= rd_issue;
         // A new source takes the next free record; records are never evicted.
         if (state_ff == ST_FINISH && rsp_free && verdict_ff == VERDICT_NEW_ENTRY) begin
            fill_ff <= fill_ff + FILL_BITS'(1);
         end
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_PENALTY:  penalty_ff  <= csr_data[PENALTY_BITS-1:0];
               CSR_WINDOW:   window_ff   <= csr_data[WINDOW_BITS-1:0];
               CSR_LIMIT:    limit_ff    <= csr_data[LIMIT_BITS-1:0];
               CSR_FAST:     fast_ff     <= csr_data[WINDOW_BITS-1:0];
               CSR_DURATION: duration_ff <= csr_data[DURATION_BITS-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Item datapath.
   always_ff @(posedge clock) begin
      if (req_take) begin
         ip_ff       <= req_data.client_ip;
         now_ff      <= TIME_BITS'(req_data.now_ms);
         scan_cnt_ff <= '0;
      end
      if (rd_issue) begin
         rd_idx_ff   <= scan_cnt_ff[IDX_BITS-1:0];
         scan_cnt_ff <= scan_cnt_ff + FILL_BITS'(1);
      end
      case (state_ff)
         ST_SCAN: begin
            if (scan_hit) begin
               rec_ff     <= rd_rec_ff;
               hit_idx_ff <= rd_idx_ff;
            end else if (scan_miss) begin
               rec_ff.addr  <= ip_ff;
               rec_ff.last  <= now_ff;
               rec_ff.block <= '0;
               rec_ff.count <= COUNT_BITS'(1);
               hit_idx_ff   <= fill_ff[IDX_BITS-1:0];
               verdict_ff   <= table_full ? VERDICT_UNTRACKED : VERDICT_NEW_ENTRY;
            end
         end
         ST_PENALTY: begin
            rec_ff.block <= alu_sat;
            verdict_ff   <= VERDICT_BLOCKED;
         end
         ST_GAP: begin
            diff_ff <= alu_result;
         end
         ST_WINDOW: begin
            // A negative gap, time having moved back, always counts as inside.
            in_win_ff <= diff_ff[TIME_BITS-1] || !alu_carry;
         end
         ST_FAST: begin
            in_fast_ff <= diff_ff[TIME_BITS-1] || !alu_carry;
         end
         ST_COUNT: begin
            rec_ff.last <= now_ff;
            verdict_ff  <= VERDICT_TRACKED;
            if (!in_win_ff) begin
               rec_ff.count <= COUNT_BITS'(1);
            end else if (count_over) begin
               rec_ff.count <= '0;
            end else begin
               rec_ff.count <= count_next[COUNT_BITS-1:0];
            end
         end
         ST_BLOCK: begin
            rec_ff.block <= alu_sat;
            verdict_ff   <= VERDICT_NEW_BLOCK;
         end
         default: begin
         end
      endcase
   end

   // Record memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         table_mem[hit_idx_ff] <= rec_ff;
      end
      if (rd_issue) begin
         rd_rec_ff <= table_mem[scan_cnt_ff[IDX_BITS-1:0]];
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_FINISH && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FINISH && rsp_free) begin
         rsp_data_ff.verdict  <= verdict_ff;
         rsp_data_ff.accepted <= (verdict_ff != VERDICT_BLOCKED) &&
                                 (verdict_ff != VERDICT_NEW_BLOCK);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The fill count never runs past the table size.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_BITS'(TABLE_ENTRIES))
      else $error("fill count exceeds table size");

   // The fill count only grows, one record at a time, when a new source is stored.
   a_fill_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && fill_ff != $past(fill_ff)) |->
         (fill_ff == $past(fill_ff) + FILL_BITS'(1) &&
          $past(verdict_ff) == VERDICT_NEW_ENTRY))
      else $error("fill count changed without a new entry");

   // A newly loaded result always comes from the finishing step of an item.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_FINISH)
      else $error("result loaded outside the finishing step");

   // Acceptance agrees with the verdict code.
   a_rsp_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.accepted ==
         (rsp_data_ff.verdict != VERDICT_BLOCKED &&
          rsp_data_ff.verdict != VERDICT_NEW_BLOCK)))
      else $error("accepted flag disagrees with verdict");

endmodule

`default_nettype wire
